// ===== design/ssram_pkg.sv =====
`timescale 1ns / 1ps

package ssram_pkg;

  // Event kinds carried in tuser
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_CS   = 2'd1;
  localparam logic [1:0] KIND_HOLD = 2'd2;

  // SPI instruction opcodes
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WRSR  = 8'h01;

  // Access modes from status bits 7:6
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_SEQ  = 2'd1;
  localparam logic [1:0] MODE_PAGE = 2'd2;

  // Result request from the command decoder to the output stage
  typedef struct packed {
    logic       valid;      // a result byte follows from this transaction
    logic       is_status;  // status byte, else memory read data
    logic [7:0] status;     // status byte value
  } result_req_t;

endpackage

// ===== design/ssram_ram.sv =====
`timescale 1ns / 1ps

module ssram_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ssram_ctrl.sv =====
`timescale 1ns / 1ps

module ssram_ctrl import ssram_pkg::*; #(
  parameter int MEM_BYTES  = 8192,
  parameter int PAGE_BYTES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [1:0]                   kind,
  input  logic [7:0]                   byte_value,
  input  logic                         line_level,
  output logic                         mem_we,
  output logic                         mem_re,
  output logic [$clog2(MEM_BYTES)-1:0] mem_addr,
  output logic [7:0]                   mem_wdata,
  output result_req_t                  req
);

  localparam int AddrW = $clog2(MEM_BYTES);
  localparam int PageW = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_ACCESS
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        hold_ign_r, hold_ign_nxt;
  logic        sel_r, sel_nxt;
  logic        hold_r, hold_nxt;
  logic        active;
  logic [15:0] addr_step;
  logic [7:0]  status;

  assign active = sel_r && !(hold_r && !hold_ign_r);
  assign status = {mode_r, 4'b0000, 1'b1, hold_ign_r};

  // Next address after a data access, by mode
  always_comb begin
    addr_step = addr_r;
    case (mode_r)
      MODE_SEQ:  addr_step = addr_r + 16'd1;
      MODE_PAGE: addr_step = {addr_r[15:PageW], addr_r[PageW-1:0] + PageW'(1)};
      default:   addr_step = addr_r;
    endcase
  end

  // Decode one transaction
  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    addr_nxt     = addr_r;
    mode_nxt     = mode_r;
    hold_ign_nxt = hold_ign_r;
    sel_nxt      = sel_r;
    hold_nxt     = hold_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    req          = '0;
    req.status   = status;
    if (in_fire) begin
      case (kind)
        KIND_CS: begin
          sel_nxt = ~line_level;
          if (line_level) begin
            phase_nxt  = PH_IDLE;
            opcode_nxt = 8'h00;
          end
        end
        KIND_HOLD: hold_nxt = line_level;
        KIND_BYTE: begin
          if (active) begin
            case (phase_r)
              PH_IDLE: begin
                opcode_nxt = byte_value;
                if (byte_value == OP_RDSR || byte_value == OP_WRSR) begin
                  phase_nxt = PH_ACCESS;
                end else if (byte_value == OP_READ || byte_value == OP_WRITE) begin
                  phase_nxt = PH_ADDR_HI;
                end
              end
              PH_ADDR_HI: begin
                addr_nxt  = {byte_value, 8'h00};
                phase_nxt = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                addr_nxt  = {addr_r[15:8], byte_value};
                phase_nxt = PH_ACCESS;
              end
              default: begin
                phase_nxt = PH_IDLE;
                if (opcode_r == OP_READ || opcode_r == OP_WRITE) begin
                  mem_re    = (opcode_r == OP_READ);
                  mem_we    = (opcode_r == OP_WRITE);
                  req.valid = (opcode_r == OP_READ);
                  addr_nxt  = addr_step;
                  if (mode_r == MODE_SEQ || mode_r == MODE_PAGE) begin
                    phase_nxt = PH_ACCESS;
                  end
                end else if (opcode_r == OP_RDSR) begin
                  req.valid     = 1'b1;
                  req.is_status = 1'b1;
                end else if (opcode_r == OP_WRSR) begin
                  mode_nxt     = byte_value[7:6];
                  hold_ign_nxt = byte_value[0];
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Store index is the address modulo the store size
  assign mem_addr  = addr_r[AddrW-1:0];
  assign mem_wdata = byte_value;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      opcode_r   <= 8'h00;
      addr_r     <= 16'h0000;
      mode_r     <= MODE_BYTE;
      hold_ign_r <= 1'b0;
      sel_r      <= 1'b0;
      hold_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      addr_r     <= addr_nxt;
      mode_r     <= mode_nxt;
      hold_ign_r <= hold_ign_nxt;
      sel_r      <= sel_nxt;
      hold_r     <= hold_nxt;
    end
  end

  // A memory access only ever comes from an accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n) (mem_we || mem_re) |-> in_fire)
    else $error("memory access without accepted transaction");

  assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
    else $error("read and write issued together");

  // Deselect always lands in idle with the opcode cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && kind == KIND_CS && line_level) |=> (phase_r == PH_IDLE && opcode_r == 8'h00))
    else $error("deselect did not return to idle");

endmodule

// ===== design/ssram_out.sv =====
`timescale 1ns / 1ps

module ssram_out import ssram_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  result_req_t req,
  input  logic [7:0]  mem_rdata,
  output logic        can_take,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata
);

  logic       pend_v_r, pend_v_nxt;
  logic       pend_st_r;
  logic [7:0] pend_status_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       pend_move;

  // Pending stage holds the result while the RAM registers its read data
  assign pend_move  = pend_v_r && (!out_valid_r || out_tready);
  assign can_take   = !(pend_v_r && !pend_move);
  assign pend_v_nxt = (pend_v_r && !pend_move) ? 1'b1 : req.valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pend_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (req.valid && can_take) begin
      pend_st_r     <= req.is_status;
      pend_status_r <= req.status;
    end
    if (pend_move) begin
      out_data_r <= pend_st_r ? pend_status_r : mem_rdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A blocked pending result keeps its slot and kind
  assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && out_valid_r && !out_tready) |=> (pend_v_r && $stable(pend_st_r)))
    else $error("pending result lost while output stalled");

  // No new result may arrive over a blocked pending one
  assert property (@(posedge clk) disable iff (!rst_n) req.valid |-> can_take)
    else $error("result request overwrote pending result");

  assert property (@(posedge clk) disable iff (!rst_n) pend_move |=> out_valid_r)
    else $error("pending result did not reach output register");

endmodule

// ===== design/spi_serial_sram_slave.sv =====
`timescale 1ns / 1ps

// SPI serial SRAM slave. Each input transaction is one event: an SPI byte,
// a chip-select change or a hold change (tuser). One transaction is taken
// per clock when input is not stalled; a READ data byte or RDSR status byte
// passes the pending read stage (a READ byte from the byte store's registered
// read port) and then the output register. Input stalls only when the output
// register and pending read stage are both full and out_tready is low. The
// byte store is not cleared at reset; reading an address never written returns
// undefined data. MEM_BYTES and PAGE_BYTES must be powers of two.
module spi_serial_sram_slave import ssram_pkg::*; #(
  parameter int MEM_BYTES  = 8192,
  parameter int PAGE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_value, [8] line_level, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] data_out
);

  localparam int AddrW = $clog2(MEM_BYTES);

  logic             in_fire;
  logic             can_take;
  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;
  result_req_t      req;

  assign in_tready = can_take;
  assign in_fire   = in_tvalid && can_take;

  ssram_ctrl #(
    .MEM_BYTES (MEM_BYTES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .kind      (in_tuser),
    .byte_value(in_tdata[7:0]),
    .line_level(in_tdata[8]),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .req       (req)
  );

  ssram_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_addr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_addr),
    .rdata(mem_rdata)
  );

  ssram_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .mem_rdata (mem_rdata),
    .can_take  (can_take),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
